[hdl/abd_pkg.sv]
// shared types, constants and address decode for the arcade board bus decoder
package abd_pkg;

	localparam int WRAM_DEPTH = 1024;
	localparam int TILE_DEPTH = 1024;
	localparam int OBJ_DEPTH  = 256;
	localparam int BYTE_W     = 8;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		REG_ROM,
		REG_OPEN,
		REG_WRAM,
		REG_TILE,
		REG_OBJ,
		REG_PORT0,
		REG_PORT1,
		REG_PORT2,
		REG_HIGH
	} region_t;

	typedef enum logic [1:0] {
		SEL_IMM,
		SEL_WRAM,
		SEL_TILE,
		SEL_OBJ
	} rd_sel_t;

	// control latch selects within 0x7000-0x77ff
	localparam logic [2:0] LATCH_NMI   = 3'd1;
	localparam logic [2:0] LATCH_STAR  = 3'd4;
	localparam logic [2:0] LATCH_HFLIP = 3'd6;
	localparam logic [2:0] LATCH_VFLIP = 3'd7;

	localparam logic CFG_DIP_ONE = 1'b0;
	localparam logic CFG_DIP_TWO = 1'b1;

	localparam logic [5:0] SREG_LFO_BASE = 6'h10;
	localparam logic [5:0] SREG_PITCH    = 6'h20;
	localparam logic [7:0] OPEN_BYTE     = 8'hff;
	localparam logic [7:0] DIP_TWO_RESET = 8'h04;

	// result of one access, apart from memory data and latch/counter state
	typedef struct packed {
		rd_sel_t    sel;
		logic [7:0] rd;
		logic       rom;
		logic       strobe;
		logic [5:0] sreg;
		logic [7:0] sval;
		logic       nmi;
	} acc_t;

	// map lies on 2 KB boundaries, so address bits 15:11 decide the region
	function automatic region_t abd_region(input logic [15:0] a);
		region_t r;
		unique case (a[15:11])
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4: r = REG_ROM;
			5'd5, 5'd6, 5'd7:             r = REG_OPEN;
			5'd8, 5'd9:                   r = REG_WRAM;
			5'd10:                        r = REG_TILE;
			5'd11:                        r = REG_OBJ;
			5'd12:                        r = REG_PORT0;
			5'd13:                        r = REG_PORT1;
			5'd14:                        r = REG_PORT2;
			default:                      r = REG_HIGH;
		endcase
		return r;
	endfunction

endpackage

[hdl/arcade_board_bus_decoder_top.sv]
// arcade board bus decoder: memory map, input ports, control latches and counters
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser operation, tdata address/write_data/buttons
//  m_*      out  m_tvalid/m_tready  tdata one result per accepted transfer
//  cfg_*    in   cfg_we             cfg_index selects the dip bank, cfg_data value
//
// one item per cycle when not stalled; stage one (ram read), then output register
// after reset the three rams are cleared by a clearing pass; s_tready stays low
// configuration writes are taken during the clearing pass as usual
// a stalled result holds in the output register; a second item waits in stage one
module arcade_board_bus_decoder_top
	import abd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] address, [23:16] write_data, [29:24] buttons, [31:30] zero
	input  logic [31:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_data, [8] from_rom, [9] sound_strobe, [15:10] sound_register,
	// [23:16] sound_value, [24] nmi_request, [25] mirror_horizontal,
	// [26] mirror_vertical, [27] starfield_enable, [59:28] star_offset,
	// [91:60] frame_total, [95:92] zero
	output logic [95:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int WRAM_AW = $clog2(WRAM_DEPTH);
	localparam int TILE_AW = $clog2(TILE_DEPTH);
	localparam int OBJ_AW  = $clog2(OBJ_DEPTH);
	localparam logic [WRAM_AW-1:0] CLR_LAST = WRAM_AW'(WRAM_DEPTH - 1);

	op_t         op;
	logic [15:0] addr;
	logic [7:0]  wd;
	logic [5:0]  btn;
	region_t     region;
	acc_t        acc;
	logic        accept;
	logic        adv_s1;
	logic        wr_acc;

	logic               clearing_q;
	logic [WRAM_AW-1:0] clr_q;
	logic [7:0]         dip1_q;
	logic [7:0]         dip2_q;
	logic               nmi_gate_q;
	logic               hflip_q;
	logic               vflip_q;
	logic               star_en_q;
	logic [31:0]        star_q;
	logic [31:0]        frame_q;

	logic  valid_s1;
	acc_t  acc_s1;
	logic  out_valid_q;
	logic [91:0] out_q;

	logic [7:0] wram_rd;
	logic [7:0] tile_rd;
	logic [7:0] obj_rd;
	logic [7:0] rd_mux;

	assign op     = op_t'(s_tuser);
	assign addr   = s_tdata[15:0];
	assign wd     = s_tdata[23:16];
	assign btn    = s_tdata[29:24];
	assign region = abd_region(addr);

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !clearing_q && (!valid_s1 || adv_s1);
	assign accept   = s_tvalid && s_tready;
	assign wr_acc   = accept && (op == OP_WRITE);

	// decode of one access
	always_comb begin
		acc     = '0;
		acc.sel = SEL_IMM;
		unique case (op)
			OP_READ: begin
				unique case (region)
					REG_ROM:   acc.rom = 1'b1;
					REG_OPEN:  acc.rd = OPEN_BYTE;
					REG_HIGH:  acc.rd = OPEN_BYTE;
					REG_WRAM:  acc.sel = SEL_WRAM;
					REG_TILE:  acc.sel = SEL_TILE;
					REG_OBJ:   acc.sel = SEL_OBJ;
					REG_PORT0: acc.rd = {3'b000, btn[3], btn[2], btn[1], 1'b0, btn[0]};
					REG_PORT1: acc.rd = {dip1_q[7:6], 4'b0000, btn[5], btn[4]};
					REG_PORT2: acc.rd = {5'b00000, dip2_q[2:0]};
					default:   acc.rd = OPEN_BYTE;
				endcase
			end
			OP_WRITE: begin
				priority case (region)
					REG_PORT0: begin
						// selects 0-3 are lamps and coin lockout: no strobe
						if (addr[2]) begin
							acc.strobe = 1'b1;
							acc.sreg   = SREG_LFO_BASE | {4'b0000, addr[1:0]};
							acc.sval   = {7'b0000000, wd[0]};
						end
					end
					REG_PORT1: begin
						acc.strobe = 1'b1;
						acc.sreg   = {3'b000, addr[2:0]};
						acc.sval   = {7'b0000000, wd[0]};
					end
					REG_HIGH: begin
						acc.strobe = 1'b1;
						acc.sreg   = SREG_PITCH;
						acc.sval   = wd;
					end
					default: ;
				endcase
			end
			OP_TICK: acc.nmi = nmi_gate_q;
			default: ;
		endcase
	end

	// rams: clearing pass owns the write port until done
	abd_ram #(.WIDTH(BYTE_W), .DEPTH(WRAM_DEPTH)) u_wram (
		.clk   (clk),
		.we    (clearing_q || (wr_acc && region == REG_WRAM)),
		.waddr (clearing_q ? clr_q : addr[WRAM_AW-1:0]),
		.wdata (clearing_q ? 8'h00 : wd),
		.re    (accept),
		.raddr (addr[WRAM_AW-1:0]),
		.rdata (wram_rd)
	);

	abd_ram #(.WIDTH(BYTE_W), .DEPTH(TILE_DEPTH)) u_tile (
		.clk   (clk),
		.we    (clearing_q || (wr_acc && region == REG_TILE)),
		.waddr (clearing_q ? clr_q[TILE_AW-1:0] : addr[TILE_AW-1:0]),
		.wdata (clearing_q ? 8'h00 : wd),
		.re    (accept),
		.raddr (addr[TILE_AW-1:0]),
		.rdata (tile_rd)
	);

	abd_ram #(.WIDTH(BYTE_W), .DEPTH(OBJ_DEPTH)) u_obj (
		.clk   (clk),
		.we    (clearing_q || (wr_acc && region == REG_OBJ)),
		.waddr (clearing_q ? clr_q[OBJ_AW-1:0] : addr[OBJ_AW-1:0]),
		.wdata (clearing_q ? 8'h00 : wd),
		.re    (accept),
		.raddr (addr[OBJ_AW-1:0]),
		.rdata (obj_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == CLR_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip1_q <= '0;
			dip2_q <= DIP_TWO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIP_ONE: dip1_q <= cfg_data;
				CFG_DIP_TWO: dip2_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// control latches and counters take their new value at the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmi_gate_q <= 1'b0;
			hflip_q    <= 1'b0;
			vflip_q    <= 1'b0;
			star_en_q  <= 1'b0;
			star_q     <= '0;
			frame_q    <= '0;
		end else if (accept) begin
			if (op == OP_WRITE && region == REG_PORT2) begin
				unique case (addr[2:0])
					LATCH_NMI:   nmi_gate_q <= wd[0];
					LATCH_STAR:  star_en_q  <= wd[0];
					LATCH_HFLIP: hflip_q    <= wd[0];
					LATCH_VFLIP: vflip_q    <= wd[0];
					default:     ;
				endcase
			end
			if (op == OP_TICK) begin
				star_q  <= star_q + 32'd1;
				frame_q <= frame_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_s1 <= acc;
		end
	end

	always_comb begin
		unique case (acc_s1.sel)
			SEL_IMM:  rd_mux = acc_s1.rd;
			SEL_WRAM: rd_mux = wram_rd;
			SEL_TILE: rd_mux = tile_rd;
			SEL_OBJ:  rd_mux = obj_rd;
			default:  rd_mux = acc_s1.rd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// latch and counter state here is that left by the item in stage one
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= {frame_q, star_q, star_en_q, vflip_q, hflip_q, acc_s1.nmi,
				acc_s1.sval, acc_s1.sreg, acc_s1.strobe, acc_s1.rom, rd_mux};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q};

`ifndef SYNTHESIS
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s_tready)
		else $error("input transfer during clearing pass");

	a_counters_agree: assert property (@(posedge clk) disable iff (!arst_n)
		star_q == frame_q)
		else $error("star and frame counters diverged");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_TICK) |=> frame_q == $past(frame_q) + 32'd1)
		else $error("tick did not advance frame counter");

	a_rom_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'h00 && !m_tdata[9]))
		else $error("rom read carries data or strobe");

	a_stage_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("item accepted while stage one is blocked");
`endif

endmodule

[hdl/abd_ram.sv]
// generic single-port-write ram with registered read
module abd_ram
	import abd_pkg::*;
#(
	parameter int WIDTH = BYTE_W,
	parameter int DEPTH = WRAM_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[dv/testbench.sv]
// self-checking testbench for the arcade board bus decoder with a predicting scoreboard
module testbench
	import abd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROM_TOP    = 'h2800;
	localparam int WRAM_BASE  = 'h4000;
	localparam int TILE_BASE  = 'h5000;
	localparam int OBJ_BASE   = 'h5800;
	localparam int PORT0_BASE = 'h6000;
	localparam int PORT1_BASE = 'h6800;
	localparam int PORT2_BASE = 'h7000;
	localparam int HIGH_BASE  = 'h7800;
	localparam int ADDR_TOP   = 'hffff;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 160;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 120;
	localparam int MAX_PRINTED  = 100;

	// result layout, highest field first
	typedef struct packed {
		logic [3:0]  spare;
		logic [31:0] frame_total;
		logic [31:0] star_offset;
		logic        starfield_enable;
		logic        mirror_vertical;
		logic        mirror_horizontal;
		logic        nmi_request;
		logic [7:0]  sound_value;
		logic [5:0]  sound_register;
		logic        sound_strobe;
		logic        from_rom;
		logic [7:0]  read_data;
	} bus_result_t;

	class bus_map_scoreboard;
		logic [7:0]  work_ram [WRAM_DEPTH];
		logic [7:0]  tile_map [TILE_DEPTH];
		logic [7:0]  object_ram [OBJ_DEPTH];
		logic        nmi_gate;
		logic        hflip;
		logic        vflip;
		logic        star_enable;
		logic [31:0] star_count;
		logic [31:0] frame_count;
		logic [7:0]  dip_one;
		logic [7:0]  dip_two;
		bus_result_t pending_results[$];
		int          errors;

		function new();
			foreach (work_ram[i]) work_ram[i] = '0;
			foreach (tile_map[i]) tile_map[i] = '0;
			foreach (object_ram[i]) object_ram[i] = '0;
			nmi_gate    = 1'b0;
			hflip       = 1'b0;
			vflip       = 1'b0;
			star_enable = 1'b0;
			star_count  = '0;
			frame_count = '0;
			dip_one     = '0;
			dip_two     = DIP_TWO_RESET;
			errors      = 0;
		endfunction

		function void set_dips(logic [7:0] one, logic [7:0] two);
			dip_one = one;
			dip_two = two;
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		// works out the result of one accepted transfer and queues it
		function void note_access(op_t op, logic [15:0] a, logic [7:0] d, logic [5:0] btn);
			bus_result_t r;
			logic [2:0]  sel;
			r   = '0;
			sel = a[2:0];
			case (op)
				OP_READ: begin
					if (a < ROM_TOP) r.from_rom = 1'b1;
					else if (a < WRAM_BASE) r.read_data = OPEN_BYTE;
					else if (a < TILE_BASE) r.read_data = work_ram[a[9:0]];
					else if (a < OBJ_BASE) r.read_data = tile_map[a[9:0]];
					else if (a < PORT0_BASE) r.read_data = object_ram[a[7:0]];
					else if (a < PORT1_BASE)
						r.read_data = {3'b000, btn[3], btn[2], btn[1], 1'b0, btn[0]};
					else if (a < PORT2_BASE)
						r.read_data = {dip_one[7:6], 4'b0000, btn[5], btn[4]};
					else if (a < HIGH_BASE) r.read_data = {5'b00000, dip_two[2:0]};
					else r.read_data = OPEN_BYTE;
				end
				OP_WRITE: begin
					if (a < WRAM_BASE) begin
						// rom and open space ignore writes
					end else if (a < TILE_BASE) begin
						work_ram[a[9:0]] = d;
					end else if (a < OBJ_BASE) begin
						tile_map[a[9:0]] = d;
					end else if (a < PORT0_BASE) begin
						object_ram[a[7:0]] = d;
					end else if (a < PORT1_BASE) begin
						// lamps and coin lockout sit on the lower four selects
						if (sel[2]) begin
							r.sound_strobe   = 1'b1;
							r.sound_register = SREG_LFO_BASE + 6'(sel[1:0]);
							r.sound_value    = {7'b0, d[0]};
						end
					end else if (a < PORT2_BASE) begin
						r.sound_strobe   = 1'b1;
						r.sound_register = 6'(sel);
						r.sound_value    = {7'b0, d[0]};
					end else if (a < HIGH_BASE) begin
						case (sel)
							LATCH_NMI:   nmi_gate    = d[0];
							LATCH_STAR:  star_enable = d[0];
							LATCH_HFLIP: hflip       = d[0];
							LATCH_VFLIP: vflip       = d[0];
							default: ;
						endcase
					end else begin
						r.sound_strobe   = 1'b1;
						r.sound_register = SREG_PITCH;
						r.sound_value    = d;
					end
				end
				OP_TICK: begin
					r.nmi_request = nmi_gate;
					star_count    = star_count + 32'd1;
					frame_count   = frame_count + 32'd1;
				end
				default: ;
			endcase
			r.mirror_horizontal = hflip;
			r.mirror_vertical   = vflip;
			r.starfield_enable  = star_enable;
			r.star_offset       = star_count;
			r.frame_total       = frame_count;
			pending_results.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		endtask

		task check_field(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want) report_mismatch(what, got, want);
		endtask

		task check_result(logic [95:0] raw);
			bus_result_t got;
			bus_result_t want;
			got = raw;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", raw[31:0], '0);
				return;
			end
			want = pending_results.pop_front();
			check_field("read_data", got.read_data, want.read_data);
			check_field("from_rom", got.from_rom, want.from_rom);
			check_field("sound_strobe", got.sound_strobe, want.sound_strobe);
			check_field("sound_register", got.sound_register, want.sound_register);
			check_field("sound_value", got.sound_value, want.sound_value);
			check_field("nmi_request", got.nmi_request, want.nmi_request);
			check_field("mirror_horizontal", got.mirror_horizontal, want.mirror_horizontal);
			check_field("mirror_vertical", got.mirror_vertical, want.mirror_vertical);
			check_field("starfield_enable", got.starfield_enable, want.starfield_enable);
			check_field("star_offset", got.star_offset, want.star_offset);
			check_field("frame_total", got.frame_total, want.frame_total);
			check_field("spare bits", got.spare, want.spare);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	bus_map_scoreboard board;
	int cycle_count = 0;
	int send_calm   = 0;

	arcade_board_bus_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// idle cycles before the next transfer, with runs of back-to-back transfers
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(20, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		int          area;
		area = $urandom_range(0, 9);
		case (area)
			0:       a = 16'($urandom_range(0, ROM_TOP - 1));
			1:       a = 16'($urandom_range(ROM_TOP, WRAM_BASE - 1));
			2:       a = 16'($urandom_range(WRAM_BASE, TILE_BASE - 1));
			3:       a = 16'($urandom_range(TILE_BASE, OBJ_BASE - 1));
			4:       a = 16'($urandom_range(OBJ_BASE, PORT0_BASE - 1));
			5:       a = 16'($urandom_range(PORT0_BASE, PORT1_BASE - 1));
			6:       a = 16'($urandom_range(PORT1_BASE, PORT2_BASE - 1));
			7:       a = 16'($urandom_range(PORT2_BASE, HIGH_BASE - 1));
			8:       a = 16'($urandom_range(HIGH_BASE, ADDR_TOP));
			default: a = 16'($urandom);
		endcase
		// keep most memory traffic on a few entries so reads find earlier writes
		if (area >= 2 && area <= 4 && $urandom_range(0, 2) != 0) begin
			if (area == 4) a[7:4] = 4'h0;
			else a[9:4] = 6'h00;
		end
		return a;
	endfunction

	task send_item(op_t op, logic [15:0] a, logic [7:0] d, logic [5:0] btn);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, btn, d, a};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		board.note_access(op, a, d, btn);
	endtask

	task send_random();
		op_t op;
		int  pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) op = OP_READ;
		else if (pick < 78) op = OP_WRITE;
		else if (pick < 95) op = OP_TICK;
		else op = OP_NONE;
		send_item(op, pick_address(), 8'($urandom), 6'($urandom));
	endtask

	// both banks in consecutive cycles, only while the block is idle
	task configure_dips(logic [7:0] one, logic [7:0] two);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DIP_ONE;
		cfg_data  <= one;
		@(posedge clk);
		cfg_index <= CFG_DIP_TWO;
		cfg_data  <= two;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_dips(one, two);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (board.pending_count() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// result side, with one long hold-off so the input stalls
	initial begin
		int gap;
		int calm;
		int seen;
		calm = 0;
		seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(calm);
			if (seen == HOLD_AT) gap = HOLD_CYCLES;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata);
			seen++;
		end
	end

	initial begin
		logic [7:0] one;
		logic [7:0] two;
		board     = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_NONE;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_DIP_ONE;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset switch settings
		send_item(OP_READ,  16'h0000, 8'h00, 6'h00);
		send_item(OP_READ,  16'h27ff, 8'hff, 6'h3f);
		send_item(OP_READ,  16'h2800, 8'h00, 6'h00);
		send_item(OP_READ,  16'h3fff, 8'h00, 6'h00);
		send_item(OP_WRITE, 16'h4000, 8'hff, 6'h00);
		send_item(OP_READ,  16'h4c00, 8'h00, 6'h00);
		send_item(OP_WRITE, 16'h57ff, 8'h5a, 6'h00);
		send_item(OP_READ,  16'h53ff, 8'h00, 6'h00);
		send_item(OP_WRITE, 16'h5fff, 8'ha5, 6'h00);
		send_item(OP_READ,  16'h58ff, 8'h00, 6'h00);
		send_item(OP_READ,  16'h6000, 8'h00, 6'h3f);
		send_item(OP_READ,  16'h6fff, 8'h00, 6'h3f);
		send_item(OP_READ,  16'h7000, 8'h00, 6'h00);
		send_item(OP_WRITE, 16'h6000, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'h6007, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'h6804, 8'hff, 6'h00);
		send_item(OP_WRITE, 16'h7001, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'h7004, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'h7006, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'h7007, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'h7000, 8'h01, 6'h00);
		send_item(OP_WRITE, 16'hffff, 8'h80, 6'h00);
		send_item(OP_WRITE, 16'h1234, 8'hff, 6'h00);
		send_item(OP_READ,  16'hffff, 8'h00, 6'h00);
		send_item(OP_TICK,  16'h0000, 8'h00, 6'h00);
		send_item(OP_NONE,  16'hffff, 8'hff, 6'h3f);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin one = 8'h00; two = 8'h00; end
				1: begin one = 8'hff; two = 8'hff; end
				2: begin one = 8'hc0; two = 8'h07; end
				3: begin one = 8'h3f; two = 8'hf8; end
				default: begin
					one = 8'($urandom);
					two = 8'($urandom);
				end
			endcase
			configure_dips(one, two);
			repeat (PHASE_ITEMS) send_random();
			drain();
		end

		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending_count() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/abd_pkg.sv
hdl/abd_ram.sv
hdl/arcade_board_bus_decoder_top.sv
dv/testbench.sv
